// File: hdl/ffba_pkg.sv
// Shared constants, codes and types of the first-fit block allocator.
package ffba_pkg;

    localparam int UNITS  = 1024;
    localparam int UNIT_W = 11;
    localparam int ADDR_W = $clog2(UNITS);
    localparam int CNT_W  = UNIT_W + 1;
    localparam int WORD_W = UNIT_W + 2;
    localparam int PADDR_W = 3;

    localparam logic [UNIT_W-1:0] UNITS_V = UNIT_W'(UNITS);
    localparam logic [UNIT_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_NEW   = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_GET   = 2'd3
    } kind_t;

    localparam logic REG_UNITS_IN_USE = 1'b0;

    // one store word per unit: used flag, block start mark, last unit of block
    typedef struct packed {
        logic              used;
        logic              mark;
        logic [UNIT_W-1:0] last;
    } word_t;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        word_t             wdata;
    } mem_req_t;

endpackage

// File: hdl/ffba_req_if.sv
// Request channel: kind and operands of one request.
interface ffba_req_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [UNIT_W-1:0] request_size;
    logic [UNIT_W-1:0] unit_address;
    logic [UNIT_W-1:0] block_ordinal;
    modport source (output valid, kind, request_size, unit_address, block_ordinal, input ready);
    modport sink   (input valid, kind, request_size, unit_address, block_ordinal, output ready);
endinterface

// File: hdl/ffba_rsp_if.sv
// Result channel: outcome of one request.
interface ffba_rsp_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [UNIT_W-1:0] block_start;
    logic [UNIT_W-1:0] block_end;
    modport source (output valid, accepted, block_start, block_end, input ready);
    modport sink   (input valid, accepted, block_start, block_end, output ready);
endinterface

// File: hdl/ffba_store.sv
// Unit store: one word per unit, single port, registered read data.
module ffba_store
    import ffba_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output word_t    rdata
);

    word_t mem [UNITS];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ffba_ctrl.sv
// Request sequencer: scans, fills and clears the unit store, holds the result.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [UNIT_W-1:0] units_in_use,
    ffba_req_if.sink          req,
    ffba_rsp_if.source        rsp,
    output mem_req_t          mem_req,
    input  word_t             mem_rdata
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [UNIT_W-1:0] size_reg, size_next;
    logic [UNIT_W-1:0] uaddr_reg, uaddr_next;
    logic [UNIT_W-1:0] ord_reg, ord_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pv_reg, pv_next;
    logic [UNIT_W-1:0] pu_reg, pu_next;
    logic [UNIT_W-1:0] run_reg, run_next;
    logic [UNIT_W-1:0] start_reg, start_next;
    logic [UNIT_W-1:0] end_reg, end_next;
    logic [UNIT_W-1:0] count_reg, count_next;
    logic              acc_reg, acc_next;
    logic              clr_rsp_reg, clr_rsp_next;
    logic              ovalid_reg, ovalid_next;
    logic              oacc_reg, oacc_next;
    logic [UNIT_W-1:0] ostart_reg, ostart_next;
    logic [UNIT_W-1:0] oend_reg, oend_next;

    logic [UNIT_W-1:0] n;
    logic              issue_ok;

    assign n = (units_in_use < UNITS_V) ? units_in_use : UNITS_V;

    always_comb
    begin
        unique case (kind_reg)
            KIND_NEW:  issue_ok = cnt_reg <= CNT_W'(n);
            KIND_FREE: issue_ok = cnt_reg >= CNT_W'(1);
            default:   issue_ok = cnt_reg <= CNT_W'(UNITS);
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        size_next    = size_reg;
        uaddr_next   = uaddr_reg;
        ord_next     = ord_reg;
        cnt_next     = cnt_reg;
        pv_next      = 1'b0;
        pu_next      = pu_reg;
        run_next     = run_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        clr_rsp_next = clr_rsp_reg;
        ovalid_next  = ovalid_reg;
        oacc_next    = oacc_reg;
        ostart_next  = ostart_reg;
        oend_next    = oend_reg;
        mem_req      = '0;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = cnt_reg[ADDR_W-1:0];
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(UNITS - 1))
                begin
                    count_next = '0;
                    if (clr_rsp_reg)
                    begin
                        acc_next   = 1'b1;
                        start_next = '0;
                        end_next   = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = kind_t'(req.kind);
                    size_next  = req.request_size;
                    uaddr_next = req.unit_address;
                    ord_next   = req.block_ordinal;
                    run_next   = '0;
                    acc_next   = 1'b0;
                    start_next = '0;
                    end_next   = '0;
                    state_next = ST_SCAN;
                    unique case (kind_t'(req.kind))
                        KIND_RESET:
                        begin
                            cnt_next     = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        KIND_NEW:
                        begin
                            cnt_next = CNT_W'(1);
                            if (req.request_size == '0)
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        KIND_FREE:
                        begin
                            cnt_next = CNT_W'(req.unit_address);
                            if (req.unit_address == '0 || req.unit_address > UNITS_V)
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        KIND_GET:
                        begin
                            cnt_next = CNT_W'(1);
                            if (req.block_ordinal == '0 || req.block_ordinal > count_reg)
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue the next unit while the previous read returns
                if (issue_ok)
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = ADDR_W'(cnt_reg - CNT_W'(1));
                    pv_next      = 1'b1;
                    pu_next      = cnt_reg[UNIT_W-1:0];
                    cnt_next     = (kind_reg == KIND_FREE) ? cnt_reg - CNT_W'(1)
                                                           : cnt_reg + CNT_W'(1);
                end
                if (pv_reg)
                begin
                    unique case (kind_reg)
                        KIND_NEW:
                        begin
                            if (mem_rdata.used)
                            begin
                                run_next = '0;
                            end
                            else
                            begin
                                run_next = run_reg + UNIT_W'(1);
                                if (run_next == size_reg)
                                begin
                                    start_next = pu_reg - size_reg + UNIT_W'(1);
                                    end_next   = pu_reg;
                                    cnt_next   = CNT_W'(start_next);
                                    pv_next    = 1'b0;
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        KIND_FREE:
                        begin
                            if (mem_rdata.mark)
                            begin
                                pv_next = 1'b0;
                                if (mem_rdata.last < uaddr_reg || mem_rdata.last > UNITS_V)
                                begin
                                    state_next = ST_RESP;
                                end
                                else
                                begin
                                    start_next = pu_reg;
                                    end_next   = mem_rdata.last;
                                    cnt_next   = CNT_W'(pu_reg);
                                    state_next = ST_FILL;
                                end
                            end
                        end
                        default:
                        begin
                            if (mem_rdata.mark)
                            begin
                                run_next = run_reg + UNIT_W'(1);
                                if (run_next == ord_reg)
                                begin
                                    acc_next   = 1'b1;
                                    start_next = pu_reg;
                                    end_next   = mem_rdata.last;
                                    pv_next    = 1'b0;
                                    state_next = ST_RESP;
                                end
                            end
                        end
                    endcase
                end
                else if (!issue_ok)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FILL:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = ADDR_W'(cnt_reg - CNT_W'(1));
                if (kind_reg == KIND_NEW)
                begin
                    mem_req.wdata.used = 1'b1;
                    mem_req.wdata.mark = cnt_reg[UNIT_W-1:0] == start_reg;
                    mem_req.wdata.last = end_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[UNIT_W-1:0] == end_reg)
                begin
                    acc_next   = 1'b1;
                    count_next = (kind_reg == KIND_NEW) ? count_reg + UNIT_W'(1)
                                                        : count_reg - UNIT_W'(1);
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // hold until the output register is free
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next  = 1'b1;
                    oacc_next    = acc_reg;
                    ostart_next  = acc_reg ? start_reg : '0;
                    oend_next    = acc_reg ? end_reg : '0;
                    clr_rsp_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            kind_reg    <= KIND_RESET;
            cnt_reg     <= '0;
            pv_reg      <= 1'b0;
            count_reg   <= '0;
            clr_rsp_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            cnt_reg     <= cnt_next;
            pv_reg      <= pv_next;
            count_reg   <= count_next;
            clr_rsp_reg <= clr_rsp_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        uaddr_reg  <= uaddr_next;
        ord_reg    <= ord_next;
        pu_reg     <= pu_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        acc_reg    <= acc_next;
        oacc_reg   <= oacc_next;
        ostart_reg <= ostart_next;
        oend_reg   <= oend_next;
    end

    assign req.ready       = state_reg == ST_IDLE;
    assign rsp.valid       = ovalid_reg;
    assign rsp.accepted    = oacc_reg;
    assign rsp.block_start = ostart_reg;
    assign rsp.block_end   = oend_reg;

    a_fill_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> cnt_reg <= CNT_W'(end_reg))
        else $error("fill ran past the block end");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= UNITS_V)
        else $error("block count above pool size");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !mem_req.we)
        else $error("store written during scan");

    a_grant_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.accepted |-> rsp.block_start <= rsp.block_end)
        else $error("result block start after end");

endmodule

// File: hdl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: config register, sequencer, unit store.
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        kind, request_size, unit_address, block_ordinal
//  rsp      out  valid/ready        accepted, block_start, block_end
//  apb      in   psel/penable       units_in_use at byte addresses 0-3
//
// A new request scans units upward from unit 1 and then writes the block; a get
// request scans upward for its block; a free scans down from the unit to its block
// start, then writes the block. The single-port unit store serves them all through one port.
// After rst_n and on each reset request a clearing pass over all units runs with
// req.ready low. A stalled result waits in the output register.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ffba_req_if.sink           req,
    ffba_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [UNIT_W-1:0] units_reg;
    mem_req_t          mem_req;
    word_t             mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_UNITS_IN_USE)
        begin
            units_reg <= pwdata[UNIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_UNITS_IN_USE) ? 32'(units_reg) : '0;

    ffba_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .units_in_use (units_reg),
        .req          (req),
        .rsp          (rsp),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata)
    );

    ffba_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule
